### rtl/freshest_link_estop_voter_macros.svh
// ----------------------------------------------------------------------------
// freshest_link_estop_voter assertion macros
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRESHEST_LINK_ESTOP_VOTER_MACROS_SVH
`define FRESHEST_LINK_ESTOP_VOTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FLEV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLEV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FLEV_ASSERT_IMP(label, ante, cons, msg)

`define FLEV_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### rtl/flev_pkg.sv
// ----------------------------------------------------------------------------
// flev_pkg
// Shared widths, register indexes, reset values and the round snapshot type.
// ----------------------------------------------------------------------------
package flev_pkg;

    localparam int IN_AGE_W  = 32;
    localparam int OUT_AGE_W = 32;
    localparam int BYTE_W    = 8;
    localparam int ELAPSED_W = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY   = 1'b1;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd300;
    localparam logic [CFG_W-1:0] DELAY_RESET   = 16'd120;

    localparam int FRESHEST_RESET = 1000000;
    localparam int FRESHEST_W     = $clog2(FRESHEST_RESET + 1);

    // control part of a finished round, handed from accumulate to final stage
    typedef struct packed {
        logic                 stop_state;
        logic                 soft_state;
        logic [ELAPSED_W-1:0] elapsed;
    } flev_snap_t;

endpackage

### rtl/freshest_link_estop_voter.sv
// ----------------------------------------------------------------------------
// freshest_link_estop_voter
// Fuses hard-stop and soft-stop link reports over a round and reports the
// freshest stop state and message age once per round.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//   in      | in        | in_valid / in_ready  | one link report per request
//   out     | out       | out_valid / out_ready| stop_active, soft_stop_active,
//           |           |                      | message_age
//
// One request per cycle unless a round-closing request waits for the snapshot;
// the running best ages update from the input register, which sets the rate.
// A round-closing request passes the input, snapshot and result registers.
// Only a round-closing request waits on a full output; mid-round requests
// flow regardless of out_ready.
// Reset restores the register defaults, restarts the round and sets the
// freshest age to its startup value.
// ----------------------------------------------------------------------------
module freshest_link_estop_voter #(
    parameter int AGE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [flev_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flev_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              link_connected,
    input  logic                              long_range_link,
    input  logic [flev_pkg::IN_AGE_W-1:0]     stop_age,
    input  logic                              stop_has_data,
    input  logic [flev_pkg::BYTE_W-1:0]       stop_byte,
    input  logic [flev_pkg::IN_AGE_W-1:0]     soft_age,
    input  logic                              soft_has_data,
    input  logic [flev_pkg::BYTE_W-1:0]       soft_byte,
    input  logic                              first_of_round,
    input  logic                              last_of_round,
    input  logic [flev_pkg::ELAPSED_W-1:0]    elapsed_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              stop_active,
    output logic                              soft_stop_active,
    output logic [flev_pkg::OUT_AGE_W-1:0]    message_age
);
    import flev_pkg::*;

    logic [CFG_W-1:0]     stop_timeout_reg;
    logic [CFG_W-1:0]     radio_delay_reg;

    logic                 snap_valid;
    logic                 snap_ready;
    logic [AGE_BITS-1:0]  snap_stop_age;
    logic [AGE_BITS-1:0]  snap_soft_age;
    flev_snap_t           snap_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_timeout_reg <= TIMEOUT_RESET;
            radio_delay_reg  <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_TIMEOUT: stop_timeout_reg <= cfg_wdata;
                CFG_IDX_DELAY:   radio_delay_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    flev_accum #(
        .AGE_BITS        (AGE_BITS)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .radio_delay     (radio_delay_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .link_connected  (link_connected),
        .long_range_link (long_range_link),
        .stop_age        (stop_age),
        .stop_has_data   (stop_has_data),
        .stop_byte       (stop_byte),
        .soft_age        (soft_age),
        .soft_has_data   (soft_has_data),
        .soft_byte       (soft_byte),
        .first_of_round  (first_of_round),
        .last_of_round   (last_of_round),
        .elapsed_ms      (elapsed_ms),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_stop_age   (snap_stop_age),
        .snap_soft_age   (snap_soft_age),
        .snap_ctl        (snap_ctl)
    );

    flev_final #(
        .AGE_BITS         (AGE_BITS)
    ) u_final (
        .clk              (clk),
        .rst_n            (rst_n),
        .stop_timeout     (stop_timeout_reg),
        .snap_valid       (snap_valid),
        .snap_ready       (snap_ready),
        .snap_stop_age    (snap_stop_age),
        .snap_soft_age    (snap_soft_age),
        .snap_ctl         (snap_ctl),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .stop_active      (stop_active),
        .soft_stop_active (soft_stop_active),
        .message_age      (message_age)
    );

endmodule

### rtl/flev_accum.sv
// ----------------------------------------------------------------------------
// flev_accum
// Input register and running best-age/state accumulation; captures a round
// snapshot on the last request of a round.
// ----------------------------------------------------------------------------
`include "freshest_link_estop_voter_macros.svh"

module flev_accum #(
    parameter int AGE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [flev_pkg::CFG_W-1:0]        radio_delay,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              link_connected,
    input  logic                              long_range_link,
    input  logic [flev_pkg::IN_AGE_W-1:0]     stop_age,
    input  logic                              stop_has_data,
    input  logic [flev_pkg::BYTE_W-1:0]       stop_byte,
    input  logic [flev_pkg::IN_AGE_W-1:0]     soft_age,
    input  logic                              soft_has_data,
    input  logic [flev_pkg::BYTE_W-1:0]       soft_byte,
    input  logic                              first_of_round,
    input  logic                              last_of_round,
    input  logic [flev_pkg::ELAPSED_W-1:0]    elapsed_ms,
    output logic                              snap_valid,
    input  logic                              snap_ready,
    output logic [AGE_BITS-1:0]               snap_stop_age,
    output logic [AGE_BITS-1:0]               snap_soft_age,
    output flev_pkg::flev_snap_t              snap_ctl
);
    import flev_pkg::*;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [AGE_BITS-1:0]  stop_age_c;
    logic [AGE_BITS-1:0]  soft_age_c;

    // input register
    logic                 ir_valid_reg;
    logic                 ir_valid_next;
    logic                 ir_conn_reg;
    logic                 ir_long_reg;
    logic [AGE_BITS-1:0]  ir_stop_age_reg;
    logic [AGE_BITS-1:0]  ir_soft_age_reg;
    logic                 ir_stop_asrt_reg;
    logic                 ir_soft_asrt_reg;
    logic                 ir_first_reg;
    logic                 ir_last_reg;
    logic [ELAPSED_W-1:0] ir_elapsed_reg;

    // running round state
    logic [AGE_BITS-1:0]  best_stop_age_reg;
    logic [AGE_BITS-1:0]  best_soft_age_reg;
    logic                 best_stop_state_reg;
    logic                 best_soft_state_reg;
    logic [AGE_BITS-1:0]  best_stop_age_next;
    logic [AGE_BITS-1:0]  best_soft_age_next;
    logic                 best_stop_state_next;
    logic                 best_soft_state_next;

    // round snapshot
    logic                 snap_valid_reg;
    logic                 snap_valid_next;
    logic [AGE_BITS-1:0]  snap_stop_age_reg;
    logic [AGE_BITS-1:0]  snap_soft_age_reg;
    flev_snap_t           snap_ctl_reg;

    logic                 snap_free;
    logic                 adv;
    logic                 in_accept;
    logic [AGE_BITS-1:0]  base_stop_age;
    logic [AGE_BITS-1:0]  base_soft_age;
    logic                 base_stop_state;
    logic                 base_soft_state;
    logic                 upd_stop;
    logic                 upd_soft;
    logic [AGE_BITS-1:0]  sel_stop_age;
    logic [AGE_BITS-1:0]  sel_soft_age;
    logic [AGE_BITS:0]    stop_sum;
    logic [AGE_BITS:0]    soft_sum;
    logic                 do_comp;

    // clamp incoming ages to the running-age width
    generate
        if (AGE_BITS >= IN_AGE_W) begin : g_age_wide
            assign stop_age_c = AGE_BITS'(stop_age);
            assign soft_age_c = AGE_BITS'(soft_age);
        end
        else begin : g_age_narrow
            assign stop_age_c = (|stop_age[IN_AGE_W-1:AGE_BITS]) ? AGE_MAX
                                                                : stop_age[AGE_BITS-1:0];
            assign soft_age_c = (|soft_age[IN_AGE_W-1:AGE_BITS]) ? AGE_MAX
                                                                : soft_age[AGE_BITS-1:0];
        end
    endgenerate

    // only a round-closing request needs room in the snapshot
    assign snap_free = !snap_valid_reg || snap_ready;
    assign adv       = ir_valid_reg && (!ir_last_reg || snap_free);
    assign in_ready  = !ir_valid_reg || adv;
    assign in_accept = in_valid && in_ready;

    assign ir_valid_next   = in_accept || (ir_valid_reg && !adv);
    assign snap_valid_next = (snap_valid_reg && !snap_ready) || (adv && ir_last_reg);

    always_comb
    begin
        base_stop_age   = ir_first_reg ? AGE_MAX : best_stop_age_reg;
        base_soft_age   = ir_first_reg ? AGE_MAX : best_soft_age_reg;
        base_stop_state = ir_first_reg ? 1'b1 : best_stop_state_reg;
        base_soft_state = ir_first_reg ? 1'b1 : best_soft_state_reg;

        upd_stop = ir_conn_reg && (ir_stop_age_reg < base_stop_age);
        upd_soft = ir_conn_reg && (ir_soft_age_reg < base_soft_age);

        sel_stop_age = upd_stop ? ir_stop_age_reg : base_stop_age;
        sel_soft_age = upd_soft ? ir_soft_age_reg : base_soft_age;

        best_stop_state_next = upd_stop ? ir_stop_asrt_reg : base_stop_state;
        best_soft_state_next = upd_soft ? ir_soft_asrt_reg : base_soft_state;

        // long-range compensation, saturating on carry out
        do_comp  = ir_conn_reg && ir_long_reg;
        stop_sum = {1'b0, sel_stop_age} + (AGE_BITS+1)'(radio_delay);
        soft_sum = {1'b0, sel_soft_age} + (AGE_BITS+1)'(radio_delay);

        best_stop_age_next = sel_stop_age;
        best_soft_age_next = sel_soft_age;
        if (do_comp)
        begin
            best_stop_age_next = stop_sum[AGE_BITS] ? AGE_MAX : stop_sum[AGE_BITS-1:0];
            best_soft_age_next = soft_sum[AGE_BITS] ? AGE_MAX : soft_sum[AGE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg        <= 1'b0;
            snap_valid_reg      <= 1'b0;
            best_stop_age_reg   <= AGE_MAX;
            best_soft_age_reg   <= AGE_MAX;
            best_stop_state_reg <= 1'b1;
            best_soft_state_reg <= 1'b1;
        end
        else
        begin
            ir_valid_reg   <= ir_valid_next;
            snap_valid_reg <= snap_valid_next;
            if (adv)
            begin
                best_stop_age_reg   <= best_stop_age_next;
                best_soft_age_reg   <= best_soft_age_next;
                best_stop_state_reg <= best_stop_state_next;
                best_soft_state_reg <= best_soft_state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ir_conn_reg      <= link_connected;
            ir_long_reg      <= long_range_link;
            ir_stop_age_reg  <= stop_age_c;
            ir_soft_age_reg  <= soft_age_c;
            ir_stop_asrt_reg <= !stop_has_data || (|stop_byte);
            ir_soft_asrt_reg <= !soft_has_data || (|soft_byte);
            ir_first_reg     <= first_of_round;
            ir_last_reg      <= last_of_round;
            ir_elapsed_reg   <= elapsed_ms;
        end
        if (adv && ir_last_reg)
        begin
            snap_stop_age_reg       <= best_stop_age_next;
            snap_soft_age_reg       <= best_soft_age_next;
            snap_ctl_reg.stop_state <= best_stop_state_next;
            snap_ctl_reg.soft_state <= best_soft_state_next;
            snap_ctl_reg.elapsed    <= ir_elapsed_reg;
        end
    end

    assign snap_valid    = snap_valid_reg;
    assign snap_stop_age = snap_stop_age_reg;
    assign snap_soft_age = snap_soft_age_reg;
    assign snap_ctl      = snap_ctl_reg;

    `FLEV_ASSERT_IMP(a_mid_round_no_wait, ir_valid_reg && !ir_last_reg, in_ready, "mid-round request stalled")
    `FLEV_ASSERT_NXT(a_snap_held, snap_valid_reg && !snap_ready, snap_valid_reg, "round snapshot dropped")
    `FLEV_ASSERT_NXT(a_first_unconnected, adv && ir_first_reg && !ir_conn_reg, best_stop_state_reg && best_soft_state_reg && (best_stop_age_reg == AGE_MAX), "round start not applied")

endmodule

### rtl/flev_final.sv
// ----------------------------------------------------------------------------
// flev_final
// Ages the freshest-message age, folds in the round's best ages, applies the
// stop timeout and holds the result register.
// ----------------------------------------------------------------------------
`include "freshest_link_estop_voter_macros.svh"

module flev_final #(
    parameter int AGE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [flev_pkg::CFG_W-1:0]        stop_timeout,
    input  logic                              snap_valid,
    output logic                              snap_ready,
    input  logic [AGE_BITS-1:0]               snap_stop_age,
    input  logic [AGE_BITS-1:0]               snap_soft_age,
    input  flev_pkg::flev_snap_t              snap_ctl,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              stop_active,
    output logic                              soft_stop_active,
    output logic [flev_pkg::OUT_AGE_W-1:0]    message_age
);
    import flev_pkg::*;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic [AGE_BITS-1:0] FRESH_INIT =
        (AGE_BITS >= FRESHEST_W) ? AGE_BITS'(FRESHEST_RESET) : AGE_MAX;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_stop_reg;
    logic                  out_soft_reg;
    logic [OUT_AGE_W-1:0]  out_age_reg;
    logic [AGE_BITS-1:0]   freshest_reg;
    logic [AGE_BITS-1:0]   freshest_next;

    logic                  take;
    logic [AGE_BITS:0]     aged_sum;
    logic [AGE_BITS-1:0]   aged;
    logic [AGE_BITS-1:0]   min1;
    logic                  timed_out;
    logic                  stop_next;
    logic [OUT_AGE_W-1:0]  age_out_next;

    assign snap_ready     = !out_valid_reg || out_ready;
    assign take           = snap_valid && snap_ready;
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_comb
    begin
        aged_sum      = {1'b0, freshest_reg} + (AGE_BITS+1)'(snap_ctl.elapsed);
        aged          = aged_sum[AGE_BITS] ? AGE_MAX : aged_sum[AGE_BITS-1:0];
        min1          = (snap_stop_age < aged) ? snap_stop_age : aged;
        freshest_next = (snap_soft_age < min1) ? snap_soft_age : min1;
        timed_out     = snap_stop_age > AGE_BITS'(stop_timeout);
        stop_next     = timed_out || snap_ctl.stop_state;
    end

    generate
        if (AGE_BITS > OUT_AGE_W) begin : g_out_sat
            assign age_out_next = (|freshest_next[AGE_BITS-1:OUT_AGE_W]) ? '1
                                  : freshest_next[OUT_AGE_W-1:0];
        end
        else begin : g_out_ext
            assign age_out_next = OUT_AGE_W'(freshest_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            freshest_reg  <= FRESH_INIT;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                freshest_reg <= freshest_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_stop_reg <= stop_next;
            out_soft_reg <= snap_ctl.soft_state;
            out_age_reg  <= age_out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign stop_active      = out_stop_reg;
    assign soft_stop_active = out_soft_reg;
    assign message_age      = out_age_reg;

    `FLEV_ASSERT_NXT(a_take_gives_result, take, out_valid_reg, "finished round gave no result")
    `FLEV_ASSERT_NXT(a_fresh_le_stop, take, freshest_reg <= $past(snap_stop_age), "freshest age above round stop age")
    `FLEV_ASSERT_NXT(a_timeout_forces_stop, take && (snap_stop_age > AGE_BITS'(stop_timeout)), out_stop_reg, "timeout did not force stop")

endmodule

### bench/flev_checker.sv
// ----------------------------------------------------------------------------
// flev_checker
// Watches the register port and both request channels of the estop voter.
// It keeps its own copy of the round state and registers, predicts each
// round verdict and compares every output request with the oldest one due.
// ----------------------------------------------------------------------------
module flev_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [flev_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [flev_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              link_connected,
    input  logic                              long_range_link,
    input  logic [flev_pkg::IN_AGE_W-1:0]     stop_age,
    input  logic                              stop_has_data,
    input  logic [flev_pkg::BYTE_W-1:0]       stop_byte,
    input  logic [flev_pkg::IN_AGE_W-1:0]     soft_age,
    input  logic                              soft_has_data,
    input  logic [flev_pkg::BYTE_W-1:0]       soft_byte,
    input  logic                              first_of_round,
    input  logic                              last_of_round,
    input  logic [flev_pkg::ELAPSED_W-1:0]    elapsed_ms,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              stop_active,
    input  logic                              soft_stop_active,
    input  logic [flev_pkg::OUT_AGE_W-1:0]    message_age,
    output int unsigned                       mismatches,
    output int unsigned                       verdicts_pending,
    output int unsigned                       verdicts_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import flev_pkg::*;

    localparam logic [IN_AGE_W-1:0] AGE_CEIL = '1;

    typedef struct packed {
        logic                 stop;
        logic                 soft_on;
        logic [OUT_AGE_W-1:0] age;
    } verdict_t;

    verdict_t              verdicts_due[$];
    logic [CFG_W-1:0]      timeout_ms;
    logic [CFG_W-1:0]      delay_ms;
    logic [IN_AGE_W-1:0]   run_stop_age;
    logic [IN_AGE_W-1:0]   run_soft_age;
    logic                  run_stop_on;
    logic                  run_soft_on;
    logic [IN_AGE_W-1:0]   freshest;
    int unsigned           fails;
    int unsigned           checked;

    function automatic logic [IN_AGE_W-1:0] add_capped(
        input logic [IN_AGE_W-1:0] a,
        input logic [IN_AGE_W-1:0] b
    );
        logic [IN_AGE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[IN_AGE_W] ? AGE_CEIL : sum[IN_AGE_W-1:0];
    endfunction

    task automatic flag_mismatch(
        input string        what,
        input logic [31:0]  got,
        input logic [31:0]  want
    );
        fails++;
        if (fails <= 40)
            $display("%0t flev_checker: round %0d %s: got 0x%0h, want 0x%0h",
                     $time, checked, what, got, want);
    endtask

    task automatic fold_report();
        verdict_t            v;
        logic [IN_AGE_W-1:0] aged;
        if (first_of_round)
        begin
            run_stop_age = AGE_CEIL;
            run_soft_age = AGE_CEIL;
            run_stop_on  = 1'b1;
            run_soft_on  = 1'b1;
        end
        if (link_connected)
        begin
            // strictly younger wins; a report with no byte counts as asserted
            if (stop_age < run_stop_age)
            begin
                run_stop_age = stop_age;
                run_stop_on  = !stop_has_data || (stop_byte != '0);
            end
            if (soft_age < run_soft_age)
            begin
                run_soft_age = soft_age;
                run_soft_on  = !soft_has_data || (soft_byte != '0);
            end
            if (long_range_link)
            begin
                run_stop_age = add_capped(run_stop_age, IN_AGE_W'(delay_ms));
                run_soft_age = add_capped(run_soft_age, IN_AGE_W'(delay_ms));
            end
        end
        if (last_of_round)
        begin
            aged = add_capped(freshest, IN_AGE_W'(elapsed_ms));
            if (run_stop_age < aged)
                aged = run_stop_age;
            if (run_soft_age < aged)
                aged = run_soft_age;
            freshest = aged;
            v.stop    = (run_stop_age > IN_AGE_W'(timeout_ms)) ? 1'b1 : run_stop_on;
            v.soft_on = run_soft_on;
            v.age     = freshest;
            verdicts_due.push_back(v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            timeout_ms   = TIMEOUT_RESET;
            delay_ms     = DELAY_RESET;
            run_stop_age = AGE_CEIL;
            run_soft_age = AGE_CEIL;
            run_stop_on  = 1'b1;
            run_soft_on  = 1'b1;
            freshest     = FRESHEST_RESET;
            fails        = 0;
            checked      = 0;
            verdicts_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_TIMEOUT)
                    timeout_ms = cfg_wdata;
                else if (cfg_index == CFG_IDX_DELAY)
                    delay_ms = cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                    flag_mismatch("result with no round closed", message_age, '0);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (stop_active !== want.stop)
                        flag_mismatch("stop_active", 32'(stop_active), 32'(want.stop));
                    if (soft_stop_active !== want.soft_on)
                        flag_mismatch("soft_stop_active", 32'(soft_stop_active),
                                      32'(want.soft_on));
                    if (message_age !== want.age)
                        flag_mismatch("message_age", message_age, want.age);
                    checked++;
                end
            end
            if (in_valid && in_ready)
                fold_report();
        end
        mismatches       <= fails;
        verdicts_pending <= verdicts_due.size();
        verdicts_checked <= checked;
    end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the freshest-link estop voter. A directed set of
// link reports covers age extremes, ties, timeout boundary, delay saturation
// and reports outside a round; random rounds then run under several register
// settings with random gaps and stalls on both channels. flev_checker does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import flev_pkg::*;

    typedef enum logic {PACE_FULL, PACE_GAPPY} pace_t;

    typedef struct {
        logic                 connected;
        logic                 long_range;
        logic [IN_AGE_W-1:0]  s_age;
        logic                 s_data;
        logic [BYTE_W-1:0]    s_byte;
        logic [IN_AGE_W-1:0]  k_age;
        logic                 k_data;
        logic [BYTE_W-1:0]    k_byte;
        logic                 first;
        logic                 last;
        logic [ELAPSED_W-1:0] elapsed;
    } link_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic                  link_connected;
    logic                  long_range_link;
    logic [IN_AGE_W-1:0]   stop_age;
    logic                  stop_has_data;
    logic [BYTE_W-1:0]     stop_byte;
    logic [IN_AGE_W-1:0]   soft_age;
    logic                  soft_has_data;
    logic [BYTE_W-1:0]     soft_byte;
    logic                  first_of_round;
    logic                  last_of_round;
    logic [ELAPSED_W-1:0]  elapsed_ms;
    logic                  out_valid;
    logic                  out_ready;
    logic                  stop_active;
    logic                  soft_stop_active;
    logic [OUT_AGE_W-1:0]  message_age;

    int unsigned mismatches;
    int unsigned verdicts_pending;
    int unsigned verdicts_checked;

    pace_t       tx_pace;
    pace_t       rx_pace;
    int unsigned hold_ticket;
    int unsigned holds_served;
    int unsigned items_sent;
    int unsigned settings_run;

    freshest_link_estop_voter i_dut (.*);

    flev_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic link_report_t report_of(
        input logic                 conn,
        input logic                 lr,
        input logic [IN_AGE_W-1:0]  sa,
        input logic                 sd,
        input logic [BYTE_W-1:0]    sb,
        input logic [IN_AGE_W-1:0]  ka,
        input logic                 kd,
        input logic [BYTE_W-1:0]    kb,
        input logic                 fst,
        input logic                 lst,
        input logic [ELAPSED_W-1:0] el
    );
        link_report_t r;
        r.connected  = conn;
        r.long_range = lr;
        r.s_age      = sa;
        r.s_data     = sd;
        r.s_byte     = sb;
        r.k_age      = ka;
        r.k_data     = kd;
        r.k_byte     = kb;
        r.first      = fst;
        r.last       = lst;
        r.elapsed    = el;
        return r;
    endfunction

    // mostly ages near the timeout, some wide, some close to the top
    function automatic logic [IN_AGE_W-1:0] random_age();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return $urandom_range(0, 600);
        if (roll < 7)
            return $urandom_range(0, 70000);
        if (roll == 7)
            return {IN_AGE_W{1'b1}} - $urandom_range(0, 70000);
        return $urandom();
    endfunction

    function automatic link_report_t random_report(input logic fst, input logic lst);
        link_report_t r;
        r.connected  = ($urandom_range(0, 99) < 85);
        r.long_range = ($urandom_range(0, 3) == 0);
        r.s_age      = random_age();
        r.s_data     = ($urandom_range(0, 4) != 0);
        r.s_byte     = ($urandom_range(0, 1) == 0) ? '0 : BYTE_W'($urandom_range(0, 255));
        r.k_age      = random_age();
        r.k_data     = ($urandom_range(0, 4) != 0);
        r.k_byte     = ($urandom_range(0, 1) == 0) ? '0 : BYTE_W'($urandom_range(0, 255));
        r.first      = fst;
        r.last       = lst;
        r.elapsed    = ($urandom_range(0, 9) < 7) ? ELAPSED_W'($urandom_range(0, 200))
                                                  : ELAPSED_W'($urandom_range(0, 65535));
        return r;
    endfunction

    task automatic pause_sender(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_report(input link_report_t r);
        link_connected  <= r.connected;
        long_range_link <= r.long_range;
        stop_age        <= r.s_age;
        stop_has_data   <= r.s_data;
        stop_byte       <= r.s_byte;
        soft_age        <= r.k_age;
        soft_has_data   <= r.k_data;
        soft_byte       <= r.k_byte;
        first_of_round  <= r.first;
        last_of_round   <= r.last;
        elapsed_ms      <= r.elapsed;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (tx_pace == PACE_GAPPY && $urandom_range(0, 9) < 4)
            pause_sender(draw_gap());
    endtask

    // hold the sender until every round verdict is in, then let the pipe settle
    task automatic quiesce();
        int unsigned spins;
        spins = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_rounds(input int unsigned target);
        int unsigned sent_here;
        int unsigned len;
        int unsigned shape;
        int unsigned k;
        sent_here = 0;
        while (sent_here < target)
        begin
            len   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            shape = $urandom_range(0, 9);
            // noise: stray report between rounds, missing first, restart mid-round
            if (shape == 0)
            begin
                send_report(random_report(1'b0, 1'b0));
                sent_here++;
            end
            for (k = 0; k < len; k++)
                send_report(random_report((k == 0 && shape != 1) ||
                                          (shape == 2 && k == len / 2),
                                          k == len - 1));
            sent_here += len;
        end
    endtask

    // output side: random stalls, plus one long hold-off per ticket from the top
    initial
    begin
        int unsigned rx_wait;
        holds_served = 0;
        out_ready    = 1'b0;
        forever
        begin
            if (hold_ticket != holds_served)
            begin
                holds_served = hold_ticket;
                out_ready <= 1'b0;
                rx_wait = 150;
            end
            else if (rx_pace == PACE_GAPPY && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                rx_wait = draw_gap();
            end
            else
            begin
                out_ready <= 1'b1;
                rx_wait = 1;
            end
            repeat (rx_wait) @(posedge clk);
        end
    end

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] timeouts [7];
        logic [CFG_W-1:0] delays   [7];
        int unsigned      p;
        timeouts = '{16'd300, 16'd0, 16'hFFFF, 16'd0,    16'hFFFF, 16'd0, 16'd200};
        delays   = '{16'd120, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,    16'd0, 16'd1};
        timeouts[5] = CFG_W'($urandom_range(0, 65535));
        delays[5]   = CFG_W'($urandom_range(0, 65535));

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_IDX_TIMEOUT;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        link_connected  = 1'b0;
        long_range_link = 1'b0;
        stop_age        = '0;
        stop_has_data   = 1'b0;
        stop_byte       = '0;
        soft_age        = '0;
        soft_has_data   = 1'b0;
        soft_byte       = '0;
        first_of_round  = 1'b0;
        last_of_round   = 1'b0;
        elapsed_ms      = '0;
        tx_pace         = PACE_FULL;
        rx_pace         = PACE_GAPPY;
        hold_ticket     = 0;
        items_sent      = 0;
        settings_run    = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, under the reset register values (timeout 300, delay 120)
        send_report(report_of(1'b1, 1'b0, 32'd0, 1'b1, 8'h00, 32'd0, 1'b1, 8'h00,
                              1'b1, 1'b1, 16'd0));
        send_report(report_of(1'b0, 1'b0, 32'd0, 1'b1, 8'h00, 32'd0, 1'b1, 8'h00,
                              1'b1, 1'b1, 16'hFFFF));
        send_report(report_of(1'b1, 1'b0, '1, 1'b0, 8'h00, '1, 1'b1, 8'hFF,
                              1'b1, 1'b1, 16'hFFFF));
        send_report(report_of(1'b1, 1'b1, 32'hFFFF_FF00, 1'b1, 8'h00, '1, 1'b1, 8'h00,
                              1'b1, 1'b1, 16'd0));
        // ties do not replace the running state
        send_report(report_of(1'b1, 1'b0, 32'd500, 1'b1, 8'h00, 32'd400, 1'b1, 8'h00,
                              1'b1, 1'b0, 16'd0));
        send_report(report_of(1'b1, 1'b0, 32'd500, 1'b1, 8'hFF, 32'd400, 1'b1, 8'h07,
                              1'b0, 1'b0, 16'd0));
        send_report(report_of(1'b1, 1'b0, 32'd499, 1'b1, 8'h00, 32'd401, 1'b0, 8'h00,
                              1'b0, 1'b1, 16'd100));
        // long-range flag on a disconnected link has no effect
        send_report(report_of(1'b0, 1'b1, 32'd10, 1'b1, 8'h00, 32'd10, 1'b1, 8'h00,
                              1'b1, 1'b0, 16'd0));
        send_report(report_of(1'b1, 1'b1, 32'd250, 1'b1, 8'h00, 32'd250, 1'b1, 8'h00,
                              1'b0, 1'b1, 16'd5));
        // no first flag: keeps accumulating on the last round's values
        send_report(report_of(1'b1, 1'b0, 32'd1000, 1'b1, 8'h00, 32'd100, 1'b1, 8'h00,
                              1'b0, 1'b1, 16'd10));
        // hard-stop timeout boundary
        send_report(report_of(1'b1, 1'b0, 32'd300, 1'b1, 8'h00, 32'd300, 1'b1, 8'h00,
                              1'b1, 1'b1, 16'd0));
        send_report(report_of(1'b1, 1'b0, 32'd301, 1'b1, 8'h00, 32'd299, 1'b1, 8'h00,
                              1'b1, 1'b1, 16'd0));
        send_report(report_of(1'b1, 1'b0, 32'd5, 1'b1, 8'h01, 32'd5, 1'b0, 8'h00,
                              1'b1, 1'b1, 16'd3));
        send_report(report_of(1'b1, 1'b0, 32'd7, 1'b1, 8'h80, 32'd7, 1'b1, 8'h80,
                              1'b1, 1'b1, 16'd3));
        send_report(report_of(1'b1, 1'b0, 32'hAAAA_AAAA, 1'b1, 8'h55, 32'h5555_5555,
                              1'b1, 8'hAA, 1'b1, 1'b0, 16'd0));
        send_report(report_of(1'b1, 1'b1, 32'h5555_5555, 1'b1, 8'hAA, 32'hAAAA_AAAA,
                              1'b1, 8'h55, 1'b0, 1'b0, 16'd0));
        send_report(report_of(1'b0, 1'b0, 32'd0, 1'b0, 8'h00, 32'd0, 1'b0, 8'h00,
                              1'b0, 1'b1, 16'hAAAA));
        send_report(report_of(1'b0, 1'b1, 32'd0, 1'b0, 8'h00, 32'd0, 1'b0, 8'h00,
                              1'b1, 1'b1, 16'h5555));
        send_report(report_of(1'b1, 1'b1, 32'd0, 1'b1, 8'h00, 32'd0, 1'b1, 8'h00,
                              1'b1, 1'b1, 16'd1));

        for (p = 0; p < 7; p++)
        begin
            quiesce();
            write_reg(CFG_IDX_TIMEOUT, timeouts[p]);
            write_reg(CFG_IDX_DELAY, delays[p]);
            settings_run++;
            tx_pace = (p % 3 == 1) ? PACE_FULL : PACE_GAPPY;
            rx_pace = (p % 3 == 2) ? PACE_FULL : PACE_GAPPY;
            run_random_rounds(50);
            if (p == 2)
            begin
                // long output hold-off while single-request rounds keep coming
                quiesce();
                tx_pace = PACE_FULL;
                hold_ticket++;
                repeat (30) send_report(random_report(1'b1, 1'b1));
                tx_pace = PACE_GAPPY;
            end
            else if (p == 4)
                quiesce();
            run_random_rounds(50);
        end
        quiesce();

        $display("summary: %0d link reports, %0d round verdicts compared, %0d register settings",
                 items_sent, verdicts_checked, settings_run);
        $display("summary: directed extremes, then random rounds with gaps, stalls and noise");
        if (mismatches == 0 && verdicts_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
